// File: rtl/descending_exchange_sorter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the descending exchange sorter
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DESCENDING_EXCHANGE_SORTER_CORE_DEFINES_SVH
`define DESCENDING_EXCHANGE_SORTER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DXS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DXS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dxsort_pkg.sv
// ----------------------------------------------------------------------------
// dxsort_pkg
// Shared sizes, entry layout and memory request bundle of the sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dxsort_pkg;

   // Capacity of one set and derived widths.
   localparam int MAX_ITEMS = 64;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);

   // Field widths of the request and the response.
   localparam int KEY_W   = 24;
   localparam int TAG_W   = 8;
   localparam int ENTRY_W = KEY_W + TAG_W;

   // One stored item: sort key and its tag.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // Access bundle from the sequencer to the item memory.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

// File: rtl/dxsort_ram.sv
// ----------------------------------------------------------------------------
// dxsort_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dxsort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/dxsort_engine.sv
// ----------------------------------------------------------------------------
// dxsort_engine
// Loads items into the memory, runs the exchange sort over it and streams the
// sorted entries out through a response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "descending_exchange_sorter_core_defines.svh"

module dxsort_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel.
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [23:0]                    req_price,
   input  wire logic [23:0]                    req_discount,
   input  wire logic [7:0]                     req_item_tag,
   input  wire logic                           req_last_item,
   // Response channel.
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [7:0]                          rsp_out_tag,
   output logic [23:0]                         rsp_out_key,
   output logic                                rsp_out_last,
   output logic                                rsp_overflow,
   // Item memory.
   output dxsort_pkg::mem_req_type             mem_req,
   input  wire logic [dxsort_pkg::ENTRY_W-1:0] mem_rd_data
);

   typedef enum logic [6:0] {
      ST_LOAD     = 7'b0000001,
      ST_FETCH    = 7'b0000010,
      ST_PRIME    = 7'b0000100,
      ST_SCAN     = 7'b0001000,
      ST_STORE    = 7'b0010000,
      ST_EMIT_RD  = 7'b0100000,
      ST_EMIT_CAP = 7'b1000000
   } state_type;

   localparam logic [dxsort_pkg::COUNT_W-1:0] CAP =
      dxsort_pkg::COUNT_W'(dxsort_pkg::MAX_ITEMS);
   localparam logic [dxsort_pkg::COUNT_W-1:0] ONE = dxsort_pkg::COUNT_W'(1);

   state_type                        state_ff, state_in;
   logic [dxsort_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                             ovf_ff, ovf_in;
   logic [dxsort_pkg::COUNT_W-1:0]   n_ff, n_in;
   logic [dxsort_pkg::COUNT_W-1:0]   i_ff, i_in;
   logic [dxsort_pkg::COUNT_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [dxsort_pkg::COUNT_W-1:0]   k_ff, k_in;
   dxsort_pkg::entry_type            held_ff, held_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   dxsort_pkg::entry_type            rsp_entry_ff, rsp_entry_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_ovf_ff, rsp_ovf_in;

   dxsort_pkg::entry_type            rd_entry;
   logic [dxsort_pkg::KEY_W-1:0]     new_key;
   logic                             req_accept;
   logic                             rsp_accept;
   logic                             rsp_free;
   logic                             out_load;
   logic                             has_room;
   logic [dxsort_pkg::COUNT_W-1:0]   rd_next;
   logic [dxsort_pkg::COUNT_W-1:0]   i_next;
   logic [dxsort_pkg::COUNT_W-1:0]   k_next;
   logic [dxsort_pkg::COUNT_W-1:0]   n_new;

   assign rd_entry   = dxsort_pkg::entry_type'(mem_rd_data);
   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign has_room   = (count_ff < CAP);
   assign rd_next    = rd_addr_ff + ONE;
   assign i_next     = i_ff + ONE;
   assign k_next     = k_ff + ONE;
   assign n_new      = has_room ? (count_ff + ONE) : count_ff;

   // Discounted price, saturated at zero.
   assign new_key = (req_discount > req_price) ? '0 : (req_price - req_discount);

   // Sequencer: load, sort by exchange, emit.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      rd_addr_in = rd_addr_ff;
      k_in       = k_ff;
      held_in    = held_ff;
      out_load   = 1'b0;
      mem_req    = '0;

      case (state_ff)
         ST_LOAD: begin
            k_in = '0;
            i_in = '0;
            if (req_accept) begin
               if (has_room) begin
                  mem_req.wr_en       = 1'b1;
                  mem_req.wr_addr     = count_ff[dxsort_pkg::ADDR_W-1:0];
                  mem_req.wr_data.key = new_key;
                  mem_req.wr_data.tag = req_item_tag;
                  count_in            = count_ff + ONE;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_item) begin
                  n_in     = n_new;
                  state_in = (n_new == ONE) ? ST_EMIT_RD : ST_FETCH;
               end
            end
         end

         // Read the entry at position i; it becomes the held entry.
         ST_FETCH: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = i_ff[dxsort_pkg::ADDR_W-1:0];
            rd_addr_in      = i_next;
            state_in        = ST_PRIME;
         end

         // Capture the held entry and start reading the first partner.
         ST_PRIME: begin
            held_in         = rd_entry;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = rd_addr_ff[dxsort_pkg::ADDR_W-1:0];
            state_in        = ST_SCAN;
         end

         // One compare per cycle; the next read overlaps the swap write.
         ST_SCAN: begin
            if (held_ff.key < rd_entry.key) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = rd_addr_ff[dxsort_pkg::ADDR_W-1:0];
               mem_req.wr_data = held_ff;
               held_in         = rd_entry;
            end
            if (rd_next < n_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_next[dxsort_pkg::ADDR_W-1:0];
               rd_addr_in      = rd_next;
            end else begin
               state_in = ST_STORE;
            end
         end

         // Write the winner back to position i and move on.
         ST_STORE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = i_ff[dxsort_pkg::ADDR_W-1:0];
            mem_req.wr_data = held_ff;
            i_in            = i_next;
            state_in        = ((i_next + ONE) < n_ff) ? ST_FETCH : ST_EMIT_RD;
         end

         // Read the next sorted entry once the response register frees up.
         ST_EMIT_RD: begin
            if (rsp_free) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = k_ff[dxsort_pkg::ADDR_W-1:0];
               state_in        = ST_EMIT_CAP;
            end
         end

         ST_EMIT_CAP: begin
            out_load = 1'b1;
            k_in     = k_next;
            if (k_next == n_ff) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_entry_in = rd_entry;
         rsp_last_in  = (k_next == n_ff);
         rsp_ovf_in   = ovf_ff;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Indexes and payload.
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      rd_addr_ff   <= rd_addr_in;
      k_ff         <= k_in;
      held_ff      <= held_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_out_tag  = rsp_entry_ff.tag;
   assign rsp_out_key  = rsp_entry_ff.key;
   assign rsp_out_last = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

   // Checks on the sequencer.
   `DXS_ASSERT_SAME(a_no_same_addr, mem_req.wr_en && mem_req.rd_en,
      mem_req.wr_addr != mem_req.rd_addr, "Read and write hit the same entry")
   `DXS_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CAP,
      "Item count exceeds capacity")
   `DXS_ASSERT_SAME(a_scan_in_set, state_ff == ST_SCAN, rd_addr_ff < n_ff,
      "Scan reads beyond the stored set")
   `DXS_ASSERT_SAME(a_no_overwrite, out_load, !rsp_valid_ff,
      "Response register loaded while a response is pending")
   `DXS_ASSERT_NEXT(a_last_ends_run, out_load && (k_next == n_ff),
      state_ff == ST_LOAD && count_ff == '0, "Run did not return to loading")

endmodule

`default_nettype wire

// File: rtl/descending_exchange_sorter_core.sv
// ----------------------------------------------------------------------------
// descending_exchange_sorter_core
// Loading: one request per cycle. Sort of n items: one compare per cycle
// through the item memory's read port and write port. Output: each sorted
// entry is read, then captured in the response register, and the next read
// waits until that register is free. Reset (synchronous, active high) clears
// the count, the overflow flag and the response valid; the item memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module descending_exchange_sorter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // price[23:0], discount[47:24], item_tag[55:48]
   input  wire logic        req_tlast,   // last_item
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // out_tag[7:0], out_key[31:8]
   output logic             rsp_tlast,   // out_last
   output logic             rsp_tuser    // overflow
);

   dxsort_pkg::mem_req_type          mem_req;
   logic [dxsort_pkg::ENTRY_W-1:0]   mem_rd_data;
   logic [7:0]                       out_tag;
   logic [23:0]                      out_key;

   // Item memory: key and tag of each stored entry.
   dxsort_ram #(
      .WIDTH(dxsort_pkg::ENTRY_W),
      .DEPTH(dxsort_pkg::MAX_ITEMS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   // Load, sort and emit sequencer.
   dxsort_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_price     (req_tdata[23:0]),
      .req_discount  (req_tdata[47:24]),
      .req_item_tag  (req_tdata[55:48]),
      .req_last_item (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_out_tag   (out_tag),
      .rsp_out_key   (out_key),
      .rsp_out_last  (rsp_tlast),
      .rsp_overflow  (rsp_tuser),
      .mem_req       (mem_req),
      .mem_rd_data   (mem_rd_data)
   );

   // Pack the response fields, lowest field first.
   assign rsp_tdata = {out_key, out_tag};

endmodule

`default_nettype wire
